>>> design/tsss_pkg.sv
// Package for the two-axis scan stepper sequencer.
// Holds the item structs, the configuration set, mode and phase types and codes.
// No dependencies; tsss_cfg, tsss_seq and the top level import it.
package tsss_pkg;

    // Configuration port widths and register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 21;

    localparam logic [CFG_INDEX_W-1:0] REG_FORWARD_TARGET  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BACKWARD_TARGET = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TOLERANCE       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DWELL_MS        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_STOP_MS         = 3'd4;

    // Reset values of the configuration registers
    localparam logic signed [20:0] FORWARD_TARGET_RST  = 21'sd1000;
    localparam logic signed [20:0] BACKWARD_TARGET_RST = -21'sd1000;
    localparam logic [7:0]         TOLERANCE_RST       = 8'd5;
    localparam logic [15:0]        DWELL_MS_RST        = 16'd2000;
    localparam logic [15:0]        STOP_MS_RST         = 16'd4000;

    // Command bytes
    localparam logic [7:0] CMD_HOME = 8'h30;
    localparam logic [7:0] CMD_SCAN = 8'h31;

    // Drive codes
    localparam logic [1:0] DRV_BRAKE = 2'd0;
    localparam logic [1:0] DRV_BACK  = 2'd1;
    localparam logic [1:0] DRV_FWD   = 2'd2;

    // Millisecond counter saturates at its all-ones value
    localparam int unsigned ELAPSED_W = 17;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_HOME = 2'd1,
        MODE_SCAN = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        PH_UNHOMED = 2'd0,
        PH_HOMED   = 2'd1,
        PH_FWD     = 2'd2,
        PH_BACK    = 2'd3
    } phase_t;

    typedef struct packed {
        logic       cmd_valid;
        logic [7:0] cmd_byte;
        logic       ms_tick;
        logic       limit_home_one;
        logic       limit_far_one;
        logic       limit_home_two;
        logic       stop_switch;
        logic       enc_one_a;
        logic       enc_one_b;
        logic       enc_two_a;
        logic       enc_two_b;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         drive_one;
        logic [1:0]         drive_two;
        logic               step_done;
        logic signed [31:0] pos_one;
        logic signed [31:0] pos_two;
        logic [1:0]         phase_one;
    } out_item_t;

    typedef struct packed {
        logic signed [20:0] forward_target;
        logic signed [20:0] backward_target;
        logic [7:0]         tolerance;
        logic [15:0]        dwell_ms;
        logic [15:0]        stop_ms;
    } cfg_t;

endpackage

>>> design/tsss_quad.sv
// Quadrature step for one encoder: adds the net count of one level change to a position.
// Depends on no other file; positions are 32 bits wide and wrap around.
module tsss_quad (
    input  logic [31:0] pos_in,
    input  logic        a,
    input  logic        b,
    input  logic        prev_a,
    input  logic        prev_b,
    output logic [31:0] pos_out
);

    logic signed [2:0] step_a;
    logic signed [2:0] step_b;
    logic signed [2:0] step_sum;

    // A change on A counts up when A and B differ; a change on B counts up when they match.
    always_comb begin
        step_a = 3'sd0;
        step_b = 3'sd0;
        if (a != prev_a) begin
            step_a = (a != b) ? 3'sd1 : -3'sd1;
        end
        if (b != prev_b) begin
            step_b = (a == b) ? 3'sd1 : -3'sd1;
        end
        step_sum = step_a + step_b;
    end

    assign pos_out = pos_in + {{29{step_sum[2]}}, step_sum};

endmodule

>>> design/tsss_cfg.sv
// Configuration register file for the scan sequencer.
// Depends on tsss_pkg for register indexes, reset values and the cfg_t set.
module tsss_cfg
    import tsss_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;

    // One write per cycle; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.forward_target  <= FORWARD_TARGET_RST;
            cfg_reg.backward_target <= BACKWARD_TARGET_RST;
            cfg_reg.tolerance       <= TOLERANCE_RST;
            cfg_reg.dwell_ms        <= DWELL_MS_RST;
            cfg_reg.stop_ms         <= STOP_MS_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_FORWARD_TARGET:  cfg_reg.forward_target  <= cfg_data;
                REG_BACKWARD_TARGET: cfg_reg.backward_target <= cfg_data;
                REG_TOLERANCE:       cfg_reg.tolerance       <= cfg_data[7:0];
                REG_DWELL_MS:        cfg_reg.dwell_ms        <= cfg_data[15:0];
                REG_STOP_MS:         cfg_reg.stop_ms         <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> design/tsss_seq.sv
// Sequencer state and per-item logic: encoder decode, ms timer, homing and raster scan.
// Depends on tsss_pkg and instantiates tsss_quad for each axis.
module tsss_seq
    import tsss_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      advance,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    mode_t                mode_reg, mode_next;
    phase_t               phase_reg, phase_next;
    logic                 homed_two_reg, homed_two_next;
    logic                 pending_reg, pending_next;
    logic                 armed_reg, armed_next;
    logic [31:0]          pos_one_reg, pos_one_next;
    logic [31:0]          pos_two_reg, pos_two_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic [1:0]           drive_one_reg, drive_one_next;
    logic [1:0]           drive_two_reg, drive_two_next;
    logic [3:0]           last_enc_reg, last_enc_next;
    logic                 primed_reg, primed_next;
    logic                 done_next;

    logic [31:0]          quad_one;
    logic [31:0]          quad_two;
    logic signed [31:0]   p1;
    logic signed [31:0]   p2;
    logic signed [31:0]   fw_ext, bk_ext, tol_ext;
    logic signed [31:0]   fw_hi, fw_lo, bk_hi, bk_lo;
    logic [ELAPSED_W-1:0] dwell_ext, stop_ext;
    mode_t                cmd_mode;

    tsss_quad u_quad_one (
        .pos_in  (pos_one_reg),
        .a       (item.enc_one_a),
        .b       (item.enc_one_b),
        .prev_a  (last_enc_reg[0]),
        .prev_b  (last_enc_reg[1]),
        .pos_out (quad_one)
    );

    tsss_quad u_quad_two (
        .pos_in  (pos_two_reg),
        .a       (item.enc_two_a),
        .b       (item.enc_two_b),
        .prev_a  (last_enc_reg[2]),
        .prev_b  (last_enc_reg[3]),
        .pos_out (quad_two)
    );

    // Target windows and time limits at the comparison widths.
    always_comb begin
        fw_ext    = {{11{cfg.forward_target[20]}}, cfg.forward_target};
        bk_ext    = {{11{cfg.backward_target[20]}}, cfg.backward_target};
        tol_ext   = {24'd0, cfg.tolerance};
        fw_hi     = fw_ext + tol_ext;
        fw_lo     = fw_ext - tol_ext;
        bk_hi     = bk_ext + tol_ext;
        bk_lo     = bk_ext - tol_ext;
        dwell_ext = {1'b0, cfg.dwell_ms};
        stop_ext  = {1'b0, cfg.stop_ms};
    end

    // Command decode; anything but home or scan idles the sequencer.
    always_comb begin
        case (item.cmd_byte)
            CMD_HOME: cmd_mode = MODE_HOME;
            CMD_SCAN: cmd_mode = MODE_SCAN;
            default:  cmd_mode = MODE_IDLE;
        endcase
    end

    // Next state. The rules run in a fixed order and later rules override earlier ones;
    // the window comparisons use the positions after decoding, before any zeroing.
    always_comb begin
        primed_next    = 1'b1;
        last_enc_next  = {item.enc_two_b, item.enc_two_a, item.enc_one_b, item.enc_one_a};
        pos_one_next   = primed_reg ? quad_one : pos_one_reg;
        pos_two_next   = primed_reg ? quad_two : pos_two_reg;
        p1             = pos_one_next;
        p2             = pos_two_next;
        elapsed_next   = elapsed_reg;
        if (item.ms_tick && (elapsed_reg != ELAPSED_MAX)) begin
            elapsed_next = elapsed_reg + 1'b1;
        end
        mode_next      = item.cmd_valid ? cmd_mode : mode_reg;
        phase_next     = phase_reg;
        homed_two_next = homed_two_reg;
        pending_next   = pending_reg;
        armed_next     = armed_reg;
        drive_one_next = drive_one_reg;
        drive_two_next = drive_two_reg;
        done_next      = 1'b0;

        case (mode_next)
            MODE_HOME: begin
                // Drive each axis forward until its home switch closes.
                if (phase_next == PH_UNHOMED) begin
                    drive_one_next = DRV_FWD;
                    if (item.limit_home_one) begin
                        drive_one_next = DRV_BRAKE;
                        phase_next     = PH_HOMED;
                        pos_one_next   = '0;
                    end
                end
                if (!homed_two_next) begin
                    drive_two_next = DRV_FWD;
                    if (item.limit_home_two) begin
                        drive_two_next = DRV_BRAKE;
                        homed_two_next = 1'b1;
                        pos_two_next   = '0;
                    end
                end
            end
            MODE_SCAN: begin
                // Dwell at the home switch after homing, then start backward.
                if (item.limit_home_one && (phase_next == PH_HOMED)) begin
                    if (elapsed_next <= dwell_ext) begin
                        drive_one_next = DRV_BRAKE;
                    end else begin
                        elapsed_next = '0;
                        pos_one_next = '0;
                        phase_next   = PH_BACK;
                    end
                end
                // Backward servo of axis one, with the far switch reversal.
                if ((phase_next == PH_HOMED) || (phase_next == PH_BACK)) begin
                    if (p1 > bk_hi) begin
                        drive_one_next = DRV_BACK;
                        armed_next     = 1'b1;
                    end else if (p1 < bk_lo) begin
                        drive_one_next = DRV_FWD;
                    end else if (elapsed_next <= dwell_ext) begin
                        drive_one_next = DRV_BRAKE;
                        if (armed_next) begin
                            done_next  = 1'b1;
                            armed_next = 1'b0;
                        end
                    end else begin
                        elapsed_next = '0;
                        pos_one_next = '0;
                    end
                    if (item.limit_far_one) begin
                        if (elapsed_next <= stop_ext) begin
                            pending_next   = 1'b1;
                            drive_one_next = DRV_BRAKE;
                        end else begin
                            elapsed_next = '0;
                            pos_one_next = '0;
                            pos_two_next = '0;
                            phase_next   = PH_FWD;
                        end
                    end
                end
                // Forward servo of axis one.
                if (phase_next == PH_FWD) begin
                    if (p1 < fw_lo) begin
                        drive_one_next = DRV_FWD;
                        armed_next     = 1'b1;
                    end else if (p1 > fw_hi) begin
                        drive_one_next = DRV_BACK;
                    end else if (elapsed_next <= dwell_ext) begin
                        drive_one_next = DRV_BRAKE;
                        if (armed_next) begin
                            done_next  = 1'b1;
                            armed_next = 1'b0;
                        end
                    end else begin
                        elapsed_next = '0;
                        pos_one_next = '0;
                    end
                end
                // Home switch reversal while going forward.
                if (item.limit_home_one && (phase_next == PH_FWD)) begin
                    if (elapsed_next <= dwell_ext) begin
                        pending_next   = 1'b1;
                        drive_one_next = DRV_BRAKE;
                    end else begin
                        elapsed_next = '0;
                        pos_one_next = '0;
                        pos_two_next = '0;
                        phase_next   = PH_BACK;
                    end
                end
                // Axis two takes its backward step when asked.
                if (pending_next) begin
                    if (p2 > bk_hi) begin
                        drive_two_next = DRV_BACK;
                    end else if (p2 < bk_lo) begin
                        drive_two_next = DRV_FWD;
                    end else begin
                        drive_two_next = DRV_BRAKE;
                        pending_next   = 1'b0;
                    end
                end
                // Stop switch brakes and unhomes both axes.
                if (item.stop_switch) begin
                    drive_one_next = DRV_BRAKE;
                    drive_two_next = DRV_BRAKE;
                    phase_next     = PH_UNHOMED;
                    homed_two_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // Result item assembled from the next state.
    always_comb begin
        result.drive_one = drive_one_next;
        result.drive_two = drive_two_next;
        result.step_done = done_next;
        result.pos_one   = pos_one_next;
        result.pos_two   = pos_two_next;
        result.phase_one = phase_next;
    end

    // Control state, updated once per item taken into the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_IDLE;
            phase_reg     <= PH_UNHOMED;
            homed_two_reg <= 1'b0;
            pending_reg   <= 1'b0;
            armed_reg     <= 1'b0;
            pos_one_reg   <= '0;
            pos_two_reg   <= '0;
            elapsed_reg   <= '0;
            drive_one_reg <= DRV_BRAKE;
            drive_two_reg <= DRV_BRAKE;
            last_enc_reg  <= '0;
            primed_reg    <= 1'b0;
        end else if (advance) begin
            mode_reg      <= mode_next;
            phase_reg     <= phase_next;
            homed_two_reg <= homed_two_next;
            pending_reg   <= pending_next;
            armed_reg     <= armed_next;
            pos_one_reg   <= pos_one_next;
            pos_two_reg   <= pos_two_next;
            elapsed_reg   <= elapsed_next;
            drive_one_reg <= drive_one_next;
            drive_two_reg <= drive_two_next;
            last_enc_reg  <= last_enc_next;
            primed_reg    <= primed_next;
        end
    end

`ifndef ASSERT_OFF
    // The held drives only ever carry brake, backward or forward.
    a_drive_codes: assert property (@(posedge aclk) disable iff (!aresetn)
        (drive_one_reg != 2'd3) && (drive_two_reg != 2'd3))
        else $error("held drive carries an undefined code");

    // The encoder history is loaded by the first item and never cleared afterwards.
    a_primed: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> primed_reg)
        else $error("encoder history not primed after an item");
`endif

endmodule

>>> design/two_axis_scan_stepper_sequencer.sv
// Top level of the two-axis scan stepper sequencer: handshakes, input and result registers.
// Depends on tsss_pkg and instantiates tsss_cfg and tsss_seq.
//
// Takes one tick item per clock cycle while m_ready is held high and returns exactly one
// result item per tick. An item is held in the input register, where the sequencer
// evaluates it against the stored state, and leaves through the result register, which
// shows the result on m_valid until m_ready takes it; a stalled result keeps the item
// waiting in the input register. The sustained rate of one item per cycle is set by the
// sequencer updating its state once per item. Configuration writes are taken in any cycle
// (cfg_ready is always high) and must only be issued while no item is in flight.
module two_axis_scan_stepper_sequencer
    import tsss_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    logic      advance;
    cfg_t      cfg;
    out_item_t result;

    // An item moves on when the result register is empty or being emptied.
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_item_reg;
    assign cfg_ready = 1'b1;

    tsss_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tsss_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg <= result;
        end
    end

`ifndef ASSERT_OFF
    // An empty input register always takes an item.
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input stage empty but not ready");

    // With both stages full and the result stalled, no item may be taken.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_ready) |-> !s_ready)
        else $error("item taken while both stages are full");

    // Every item moved on shows up as a result in the next cycle.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("item moved on without a result");
`endif

endmodule
